// ===== rtl/box_filter_3x3_edge_mean_core_defines.svh =====
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_mean_core_defines.svh
// Assertion macros for the 3x3 edge mean filter core.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_3X3_EDGE_MEAN_CORE_DEFINES_SVH
`define BOX_FILTER_3X3_EDGE_MEAN_CORE_DEFINES_SVH

// Condition holds at every edge outside reset.
`define BFEM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BFEM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BFEM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bfem_pkg.sv =====
// ----------------------------------------------------------------------------
// bfem_pkg
// Shared types, widths and the mean divider for the 3x3 edge mean filter.
// ----------------------------------------------------------------------------
package bfem_pkg;

	localparam int PIX_W    = 8;
	localparam int COORD_W  = 10;
	localparam int CFG_W    = 11;
	localparam int SUM_W    = 12;   // 9 * 255 fits
	localparam int MAX_RES  = 4;
	localparam int NRES_W   = 3;
	localparam int SLOT_W   = 2;
	localparam int CFG_RESET_SIZE = 10;

	// reciprocal multiply: exact for every sum this block can produce
	localparam int PROD_W = 24;
	localparam logic [SUM_W-1:0] RECIP_6 = 12'd2731;
	localparam int               SHIFT_6 = 14;
	localparam logic [SUM_W-1:0] RECIP_9 = 12'd3641;
	localparam int               SHIFT_9 = 15;

	typedef enum logic [1:0] {
		DIV_BY_4,
		DIV_BY_6,
		DIV_BY_9
	} div_sel_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		div_sel_t         div;
		logic             row_cur;   // 1: current row, 0: row above
		logic             col_cur;   // 1: current column, 0: column before
	} res_slot_t;

	typedef struct packed {
		logic r_ge1;
		logic r_ge2;
		logic r_last;
		logic c_ge1;
		logic c_ge2;
		logic c_last;
	} pos_flags_t;

	function automatic logic [PIX_W-1:0] mean_of(input logic [SUM_W-1:0] s,
	                                             input div_sel_t d);
		logic [PROD_W-1:0] prod;
		logic [PIX_W-1:0]  q;
		prod = '0;
		q    = '0;
		case (d)
			DIV_BY_4: begin
				q = PIX_W'(s >> 2);
			end
			DIV_BY_6: begin
				prod = PROD_W'(s) * PROD_W'(RECIP_6);
				q    = PIX_W'(prod >> SHIFT_6);
			end
			DIV_BY_9: begin
				prod = PROD_W'(s) * PROD_W'(RECIP_9);
				q    = PIX_W'(prod >> SHIFT_9);
			end
			default: begin
				q = '0;
			end
		endcase
		return q;
	endfunction

endpackage

// ===== rtl/bfem_pix_if.sv =====
// ----------------------------------------------------------------------------
// bfem_pix_if
// Pixel stream channel: valid/ready with one 8-bit pixel per transaction.
// ----------------------------------------------------------------------------
interface bfem_pix_if;
	logic                     valid;
	logic                     ready;
	logic [bfem_pkg::PIX_W-1:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

// ===== rtl/bfem_res_if.sv =====
// ----------------------------------------------------------------------------
// bfem_res_if
// Result stream channel: filtered pixel with its coordinates and last flag.
// ----------------------------------------------------------------------------
interface bfem_res_if;
	logic                         valid;
	logic                         ready;
	logic [bfem_pkg::COORD_W-1:0] out_row;
	logic [bfem_pkg::COORD_W-1:0] out_col;
	logic [bfem_pkg::PIX_W-1:0]   mean_value;
	logic                         last;

	modport source(output valid, output out_row, output out_col, output mean_value,
	               output last, input ready);
	modport sink(input valid, input out_row, input out_col, input mean_value,
	             input last, output ready);
endinterface

// ===== rtl/bfem_line_ram.sv =====
// ----------------------------------------------------------------------------
// bfem_line_ram
// Single-port line store, synchronous write, registered read.
// ----------------------------------------------------------------------------
module bfem_line_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [AW-1:0]              addr,
	input  logic [bfem_pkg::PIX_W-1:0] wdata,
	output logic [bfem_pkg::PIX_W-1:0] rdata
);

	logic [bfem_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/bfem_window.sv =====
// ----------------------------------------------------------------------------
// bfem_window
// Two-column window and per-pixel result builder (sums and divisor codes).
// ----------------------------------------------------------------------------
module bfem_window (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      clear,
	input  logic                                      step,
	input  logic [bfem_pkg::PIX_W-1:0]                top,
	input  logic [bfem_pkg::PIX_W-1:0]                mid,
	input  logic [bfem_pkg::PIX_W-1:0]                bot,
	input  bfem_pkg::pos_flags_t                      flags,
	output bfem_pkg::res_slot_t [bfem_pkg::MAX_RES-1:0] slots,
	output logic [bfem_pkg::NRES_W-1:0]               n_res
);

	localparam int SW = bfem_pkg::SUM_W;

	// w_q[0..2]: column c-2 (upper, middle, lower); w_q[3..5]: column c-1
	logic [bfem_pkg::PIX_W-1:0] w_q [6];

	logic [SW-1:0] up2, up1, up0, lo2, lo1, lo0;
	bfem_pkg::res_slot_t [bfem_pkg::MAX_RES-1:0] cand;
	logic [bfem_pkg::MAX_RES-1:0]                cand_en;
	bfem_pkg::res_slot_t [bfem_pkg::MAX_RES-1:0] slots_d;
	logic [bfem_pkg::NRES_W-1:0]                 cnt;

	always_comb begin
		up2 = (flags.r_ge2 ? SW'(w_q[0]) : '0) + SW'(w_q[1]) + SW'(w_q[2]);
		up1 = (flags.r_ge2 ? SW'(w_q[3]) : '0) + SW'(w_q[4]) + SW'(w_q[5]);
		up0 = (flags.r_ge2 ? SW'(top) : '0) + SW'(mid) + SW'(bot);
		lo2 = SW'(w_q[1]) + SW'(w_q[2]);
		lo1 = SW'(w_q[4]) + SW'(w_q[5]);
		lo0 = SW'(mid) + SW'(bot);

		// row above, column before
		cand_en[0]      = flags.r_ge1 && flags.c_ge1;
		cand[0].sum     = up1 + up0 + (flags.c_ge2 ? up2 : '0);
		cand[0].div     = (flags.r_ge2 && flags.c_ge2) ? bfem_pkg::DIV_BY_9 :
		                  (flags.r_ge2 || flags.c_ge2) ? bfem_pkg::DIV_BY_6 :
		                  bfem_pkg::DIV_BY_4;
		cand[0].row_cur = 1'b0;
		cand[0].col_cur = 1'b0;

		// row above, right edge column
		cand_en[1]      = flags.r_ge1 && flags.c_last;
		cand[1].sum     = up1 + up0;
		cand[1].div     = flags.r_ge2 ? bfem_pkg::DIV_BY_6 : bfem_pkg::DIV_BY_4;
		cand[1].row_cur = 1'b0;
		cand[1].col_cur = 1'b1;

		// last row, column before
		cand_en[2]      = flags.r_ge1 && flags.r_last && flags.c_ge1;
		cand[2].sum     = lo1 + lo0 + (flags.c_ge2 ? lo2 : '0);
		cand[2].div     = flags.c_ge2 ? bfem_pkg::DIV_BY_6 : bfem_pkg::DIV_BY_4;
		cand[2].row_cur = 1'b1;
		cand[2].col_cur = 1'b0;

		// last row, right edge column
		cand_en[3]      = flags.r_ge1 && flags.r_last && flags.c_last;
		cand[3].sum     = lo1 + lo0;
		cand[3].div     = bfem_pkg::DIV_BY_4;
		cand[3].row_cur = 1'b1;
		cand[3].col_cur = 1'b1;

		// pack enabled candidates in emission order
		slots_d = '0;
		cnt     = '0;
		for (int k = 0; k < bfem_pkg::MAX_RES; k++) begin
			if (cand_en[k]) begin
				slots_d[cnt[bfem_pkg::SLOT_W-1:0]] = cand[k];
				cnt = cnt + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				w_q[i] <= '0;
			end
			n_res <= '0;
		end else if (clear) begin
			for (int i = 0; i < 6; i++) begin
				w_q[i] <= '0;
			end
		end else if (step) begin
			w_q[0] <= w_q[3];
			w_q[1] <= w_q[4];
			w_q[2] <= w_q[5];
			w_q[3] <= top;
			w_q[4] <= mid;
			w_q[5] <= bot;
			n_res  <= cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			slots <= slots_d;
		end
	end

endmodule

// ===== rtl/box_filter_3x3_edge_mean_core.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_mean_core
// 3x3 mean filter with edge-aware divisor over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   pixels  : sink channel, one pixel per transaction in raster order.
//   results : source channel, zero to four filtered pixels per input pixel,
//             each with row/column; last marks the final one of that input.
//   cfg_we/cfg_data : writes image_size (clamped to 2..MAX_SIZE) and restarts
//             the frame. Write only while the core is idle.
// Timing:
//   One pixel at a time. Accept -> line store read + window update
//   -> results loaded into the output register at one per cycle while the
//   output is not stalled. The core takes no new pixel until every result
//   of the current one is loaded, so its pixel rate is set by the
//   single-port line store read/write sequence and the single output
//   register. The first result is registered after the window update.
// Reset:
//   Counters, window and bank select clear; image_size returns to 10 or, if
//   smaller, MAX_SIZE. Line stores are not cleared; only written data is used.
// Backpressure:
//   A stalled result holds in the output register; ready on the input drops
//   until all results of the current pixel are loaded.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_edge_mean_core_defines.svh"

module box_filter_3x3_edge_mean_core #(
	parameter int MAX_SIZE = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bfem_pkg::CFG_W-1:0] cfg_data,
	bfem_pix_if.sink                   pixels,
	bfem_res_if.source                 results
);

	localparam int CW   = $clog2(MAX_SIZE);           // coordinate / address width
	localparam int SZW  = CW + 1;                     // holds MAX_SIZE itself
	localparam int CMPW = (SZW > bfem_pkg::CFG_W) ? SZW : bfem_pkg::CFG_W;
	localparam int RESET_SIZE = (MAX_SIZE < bfem_pkg::CFG_RESET_SIZE) ?
	                            MAX_SIZE : bfem_pkg::CFG_RESET_SIZE;

	typedef enum logic [1:0] {
		S_IDLE,
		S_STEP,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [SZW-1:0]  size_q;
	logic [CMPW-1:0] cfg_ext;
	logic [SZW-1:0]  size_d;
	logic [CW-1:0]   last_idx;

	// position of the next pixel, and of the pixel in flight
	logic [CW-1:0] r_q, c_q;
	logic [CW-1:0] cur_r_q, cur_c_q;
	logic          bank_q;      // 1: line store B holds the upper row
	logic [bfem_pkg::PIX_W-1:0] pix_q;

	logic          accept;
	logic          in_wrap;
	logic [CW-1:0] in_r, in_c;

	// line stores
	logic          ram_re, we_a, we_b;
	logic [CW-1:0] ram_addr;
	logic [bfem_pkg::PIX_W-1:0] rd_a, rd_b, top_pix, mid_pix;

	// window / results
	bfem_pkg::pos_flags_t                        flags;
	bfem_pkg::res_slot_t [bfem_pkg::MAX_RES-1:0] slots;
	logic [bfem_pkg::NRES_W-1:0]                 n_res;
	logic [bfem_pkg::SLOT_W-1:0]                 k_q;
	bfem_pkg::res_slot_t                         slot;
	logic [CW-1:0]                               res_r, res_c;
	logic                                        slot_last;
	logic                                        load_res;

	// output register
	logic                           res_valid_q;
	logic [bfem_pkg::COORD_W-1:0]   out_row_q, out_col_q;
	logic [bfem_pkg::PIX_W-1:0]     mean_q;
	logic                           last_q;

	// ---- configuration clamp --------------------------------------------
	always_comb begin
		cfg_ext = CMPW'(cfg_data);
		if (cfg_ext < CMPW'(2)) begin
			size_d = SZW'(2);
		end else if (cfg_ext > CMPW'(MAX_SIZE)) begin
			size_d = SZW'(MAX_SIZE);
		end else begin
			size_d = SZW'(cfg_ext);
		end
	end

	assign last_idx = CW'(size_q - 1'b1);

	// ---- input side -----------------------------------------------------
	assign pixels.ready = (state_q == S_IDLE);
	assign accept       = pixels.valid && pixels.ready;

	// out-of-frame position restarts at the origin
	assign in_wrap = (SZW'(r_q) >= size_q) || (SZW'(c_q) >= size_q);
	assign in_r    = in_wrap ? '0 : r_q;
	assign in_c    = in_wrap ? '0 : c_q;

	// read both stores on accept, write the upper store in the next cycle
	assign ram_re   = accept;
	assign we_a     = (state_q == S_STEP) && !bank_q;
	assign we_b     = (state_q == S_STEP) && bank_q;
	assign ram_addr = (state_q == S_STEP) ? cur_c_q : in_c;

	bfem_line_ram #(.DEPTH(MAX_SIZE), .AW(CW)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (pix_q),
		.rdata (rd_a)
	);

	bfem_line_ram #(.DEPTH(MAX_SIZE), .AW(CW)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (pix_q),
		.rdata (rd_b)
	);

	assign top_pix = bank_q ? rd_b : rd_a;
	assign mid_pix = bank_q ? rd_a : rd_b;

	// ---- window ---------------------------------------------------------
	always_comb begin
		flags.r_ge1  = (cur_r_q != '0);
		flags.r_ge2  = (SZW'(cur_r_q) >= SZW'(2));
		flags.r_last = (cur_r_q == last_idx);
		flags.c_ge1  = (cur_c_q != '0);
		flags.c_ge2  = (SZW'(cur_c_q) >= SZW'(2));
		flags.c_last = (cur_c_q == last_idx);
	end

	bfem_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_we),
		.step   (state_q == S_STEP),
		.top    (top_pix),
		.mid    (mid_pix),
		.bot    (pix_q),
		.flags  (flags),
		.slots  (slots),
		.n_res  (n_res)
	);

	// ---- position counters and bank select ------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SZW'(RESET_SIZE);
			r_q     <= '0;
			c_q     <= '0;
			cur_r_q <= '0;
			cur_c_q <= '0;
			bank_q  <= 1'b0;
		end else if (cfg_we) begin
			size_q <= size_d;
			r_q    <= '0;
			c_q    <= '0;
		end else begin
			if (accept) begin
				cur_r_q <= in_r;
				cur_c_q <= in_c;
			end
			if (state_q == S_STEP) begin
				if (cur_c_q == last_idx) begin
					c_q    <= '0;
					bank_q <= ~bank_q;
					r_q    <= (cur_r_q == last_idx) ? '0 : cur_r_q + 1'b1;
				end else begin
					c_q <= cur_c_q + 1'b1;
					r_q <= cur_r_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixels.pixel;
		end
	end

	// ---- result sequencing ----------------------------------------------
	assign slot      = slots[k_q];
	assign res_r     = slot.row_cur ? cur_r_q : cur_r_q - 1'b1;
	assign res_c     = slot.col_cur ? cur_c_q : cur_c_q - 1'b1;
	assign slot_last = (bfem_pkg::NRES_W'(k_q) == n_res - 1'b1);

	// output register takes the next result when empty or draining
	assign load_res  = (state_q == S_EMIT) && (n_res != '0) &&
	                   (!res_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			res_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			mean_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					k_q     <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (n_res == '0) begin
						state_q <= S_IDLE;
					end else if (load_res) begin
						out_row_q   <= bfem_pkg::COORD_W'(res_r);
						out_col_q   <= bfem_pkg::COORD_W'(res_c);
						mean_q      <= bfem_pkg::mean_of(slot.sum, slot.div);
						last_q      <= slot_last;
						if (slot_last) begin
							k_q     <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid      = res_valid_q;
	assign results.out_row    = out_row_q;
	assign results.out_col    = out_col_q;
	assign results.mean_value = mean_q;
	assign results.last       = last_q;

	// ---- assertions -----------------------------------------------------
	`BFEM_ASSERT_ALWAYS(a_ram_no_rw_overlap, !(ram_re && (we_a || we_b)), "store read/write clash")
	`BFEM_ASSERT_NEXT(a_accept_to_step, accept, state_q == S_STEP, "accept without update step")
	`BFEM_ASSERT_SAME(a_slot_in_range, load_res, bfem_pkg::NRES_W'(k_q) < n_res, "index overrun")

endmodule
